// ===== rtl/assert_macros.svh =====
// Assertion macros used by the frame gatherer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, masked while reset is asserted
`define SLX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included
`define SLX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/slxfg_pkg.sv =====
// Package for the sync/length/XOR frame gatherer: sizes, register map, sequencer states.
`timescale 1ns / 1ps
package slxfg_pkg;

  // Largest payload length that is buffered
  localparam int unsigned MaxLen     = 32;
  // Sync, length, type and checksum
  localparam int unsigned Overhead   = 4;
  localparam int unsigned StoreDepth = MaxLen + Overhead;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  // Byte counter also holds the discard count of an overlong frame (up to 257)
  localparam int unsigned CntW       = 9;

  // Register map
  localparam int unsigned AddrW      = 3;
  localparam logic [0:0]  RegSync    = 1'b0;
  localparam logic [7:0]  SyncReset  = 8'hA4;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_BODY,
    ST_DROP,
    ST_EMIT_RD,
    ST_EMIT_WR
  } phase_e;

endpackage

// ===== rtl/sync_length_xor_frame_gatherer.sv =====
// Frame gatherer: hunts for sync, buffers a frame, checks its XOR and replays it.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------
//  in       | in_valid_i / in_stall_o    | in_byte_i[7:0]
//  out      | out_valid_o / out_stall_i  | out_byte_o[7:0], out_last_o
//  config   | APB psel/penable/pready    | paddr, pwdata, prdata (32 bit)
//
// Input bytes are taken one per cycle while hunting, gathering or discarding.
// A frame of L+4 bytes that passes its check is replayed from the frame buffer
// byte by byte (a buffer read, then an output load that waits out a stall);
// in_stall_o is high for that whole replay.
// Reset clears the sequencer and the output valid flag; the buffer and output byte are not cleared.
// A stalled output holds its byte while the sequencer takes new input.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sync_length_xor_frame_gatherer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input byte stream
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  // validated frame bytes
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slxfg_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  slxfg_pkg::phase_e st_q, st_d;

  logic [7:0]                       sync_q;
  logic [7:0]                       len_q, len_d;
  logic [slxfg_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [7:0]                       xor_q, xor_d;
  logic [7:0]                       chk_q, chk_d;
  logic [slxfg_pkg::StoreAw-1:0]    emit_idx_q, emit_idx_d;
  logic [slxfg_pkg::StoreAw-1:0]    emit_cnt_q, emit_cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic [7:0]                       out_byte_q, out_byte_d;
  logic                             out_last_q, out_last_d;

  // frame buffer
  logic [7:0]                       mem [slxfg_pkg::StoreDepth];
  logic [7:0]                       mem_rd_q;
  logic                             mem_we;
  logic [slxfg_pkg::StoreAw-1:0]    mem_wa;

  logic                             in_xfer;
  logic                             cfg_wr;
  logic                             cnt_at_chk;
  logic                             emit_last;
  logic                             out_free;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == slxfg_pkg::RegSync) ? {24'd0, sync_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= slxfg_pkg::SyncReset;
    end else if (cfg_wr && (paddr[2] == slxfg_pkg::RegSync)) begin
      sync_q <= pwdata[7:0];
    end
  end

  // Handshake
  assign in_stall_o  = (st_q == slxfg_pkg::ST_EMIT_RD) || (st_q == slxfg_pkg::ST_EMIT_WR);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign cnt_at_chk = cnt_q >= ({1'b0, len_q} + slxfg_pkg::CntW'(3));
  assign emit_last  = emit_idx_q == emit_cnt_q;

  // Sequencer: next state, counters, buffer write and output load
  always_comb begin
    st_d        = st_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    xor_d       = xor_q;
    chk_d       = chk_q;
    emit_idx_d  = emit_idx_q;
    emit_cnt_d  = emit_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    case (st_q)
      slxfg_pkg::ST_HUNT: begin
        if (in_xfer && (in_byte_i == sync_q)) begin
          mem_we = 1'b1;
          mem_wa = '0;
          xor_d  = in_byte_i;
          cnt_d  = slxfg_pkg::CntW'(1);
          st_d   = slxfg_pkg::ST_LEN;
        end
      end
      slxfg_pkg::ST_LEN: begin
        if (in_xfer) begin
          len_d = in_byte_i;
          xor_d = xor_q ^ in_byte_i;
          if (in_byte_i > 8'(slxfg_pkg::MaxLen)) begin
            // overlong: discard type, data and checksum
            cnt_d = {1'b0, in_byte_i} + slxfg_pkg::CntW'(2);
            st_d  = slxfg_pkg::ST_DROP;
          end else begin
            mem_we = 1'b1;
            mem_wa = slxfg_pkg::StoreAw'(1);
            cnt_d  = slxfg_pkg::CntW'(2);
            st_d   = slxfg_pkg::ST_BODY;
          end
        end
      end
      slxfg_pkg::ST_BODY: begin
        if (in_xfer) begin
          if (cnt_at_chk) begin
            if (in_byte_i == xor_q) begin
              chk_d      = in_byte_i;
              emit_cnt_d = cnt_q[slxfg_pkg::StoreAw-1:0];
              emit_idx_d = '0;
              st_d       = slxfg_pkg::ST_EMIT_RD;
            end else begin
              st_d = slxfg_pkg::ST_HUNT;
            end
            cnt_d = '0;
            xor_d = '0;
          end else begin
            mem_we = 1'b1;
            mem_wa = cnt_q[slxfg_pkg::StoreAw-1:0];
            xor_d  = xor_q ^ in_byte_i;
            cnt_d  = cnt_q + slxfg_pkg::CntW'(1);
          end
        end
      end
      slxfg_pkg::ST_DROP: begin
        if (in_xfer) begin
          if (cnt_q <= slxfg_pkg::CntW'(1)) begin
            cnt_d = '0;
            xor_d = '0;
            st_d  = slxfg_pkg::ST_HUNT;
          end else begin
            cnt_d = cnt_q - slxfg_pkg::CntW'(1);
          end
        end
      end
      slxfg_pkg::ST_EMIT_RD: begin
        // buffer read of entry emit_idx_q lands in mem_rd_q
        st_d = slxfg_pkg::ST_EMIT_WR;
      end
      slxfg_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = emit_last ? chk_q : mem_rd_q;
          out_last_d  = emit_last;
          if (emit_last) begin
            st_d = slxfg_pkg::ST_HUNT;
          end else begin
            emit_idx_d = emit_idx_q + slxfg_pkg::StoreAw'(1);
            st_d       = slxfg_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        st_d = slxfg_pkg::ST_HUNT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= slxfg_pkg::ST_HUNT;
      len_q       <= '0;
      cnt_q       <= '0;
      xor_q       <= '0;
      emit_idx_q  <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      xor_q       <= xor_d;
      emit_idx_q  <= emit_idx_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chk_q      <= chk_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  // Frame buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= in_byte_i;
    end
    mem_rd_q <= mem[emit_idx_q];
  end

  // Replay index never runs past the checksum slot
  `SLX_ASSERT(a_emit_idx_bound, (in_stall_o |-> (emit_idx_q <= emit_cnt_q)), "replay index past frame end")
  // A replay starts with a frame of at least sync, length and type, within the buffer
  `SLX_ASSERT(a_emit_cnt_range, ((st_q == slxfg_pkg::ST_EMIT_RD && emit_idx_q == '0) |-> ((emit_cnt_q >= slxfg_pkg::StoreAw'(3)) && (emit_cnt_q <= slxfg_pkg::StoreAw'(slxfg_pkg::StoreDepth - 1)))), "replay length out of range")
  // While gathering, length fits the buffer and the count never passes the checksum position
  `SLX_ASSERT(a_body_bound, ((st_q == slxfg_pkg::ST_BODY) |-> ((len_q <= 8'(slxfg_pkg::MaxLen)) && (cnt_q <= ({1'b0, len_q} + slxfg_pkg::CntW'(3))))), "gather count out of range")

endmodule
